[design/abst_pkg.sv]
`timescale 1ns / 1ps

package abst_pkg;

    // Default geometry
    localparam int LEVELS_DEF   = 6;
    localparam int KEY_BITS_DEF = 16;

    // Fixed field widths on the ports
    localparam int OP_W     = 1;
    localparam int KEY_W    = 16;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 6;
    localparam int HEIGHT_W = 4;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 1'b0;
    localparam logic [OP_W-1:0] OP_SEARCH = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO = 2'd2;

    // One result, as handed from the sequencer to the output register
    typedef struct packed {
        logic [HEIGHT_W-1:0] tree_height;
        logic [KEY_W-1:0]    max_key;
        logic [KEY_W-1:0]    min_key;
        logic [SLOT_W-1:0]   slot;
        logic [STATUS_W-1:0] status;
        logic                found;
    } res_t;

endpackage

[design/abst_mem.sv]
`timescale 1ns / 1ps

module abst_mem #(
    parameter int AW    = 6,
    parameter int DW    = 16,
    parameter int DEPTH = 63
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/abst_ctrl.sv]
`timescale 1ns / 1ps

module abst_ctrl #(
    parameter int LEVELS   = abst_pkg::LEVELS_DEF,
    parameter int KEY_BITS = abst_pkg::KEY_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // request side
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [abst_pkg::OP_W-1:0]   in_op,
    input  logic [abst_pkg::KEY_W-1:0]  in_key,
    // result side
    output logic                        res_valid,
    input  logic                        res_ready,
    output abst_pkg::res_t              res,
    // tree store
    output logic                        mem_we,
    output logic [LEVELS-1:0]           mem_waddr,
    output logic [KEY_BITS-1:0]         mem_wdata,
    output logic [LEVELS-1:0]           mem_raddr,
    input  logic [KEY_BITS-1:0]         mem_rdata
);

    localparam int AW         = LEVELS;
    localparam int DW         = (LEVELS > 2) ? $clog2(LEVELS) : 1;
    localparam int STORE_SIZE = (1 << LEVELS) - 1;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_WALK  = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic [AW-1:0]                   clr_reg, clr_next;
    logic [AW-1:0]                   idx_reg, idx_next;
    logic [DW-1:0]                   depth_reg, depth_next;
    logic [abst_pkg::OP_W-1:0]       op_reg, op_next;
    logic [KEY_BITS-1:0]             key_reg, key_next;
    logic                            found_reg, found_next;
    logic [abst_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [AW-1:0]                   slot_reg, slot_next;
    logic [KEY_BITS-1:0]             min_reg, min_next;
    logic [KEY_BITS-1:0]             max_reg, max_next;
    logic [DW-1:0]                   height_reg, height_next;
    logic                            empty_reg, empty_next;

    logic [KEY_BITS+abst_pkg::KEY_W-1:0] key_ext;
    logic [KEY_BITS-1:0]             key_eff;
    logic                            node_empty;
    logic                            node_hit;
    logic                            go_right;
    logic                            at_last;
    logic [AW:0]                     child_w;
    logic [AW-1:0]                   child;

    logic [DW+abst_pkg::HEIGHT_W-1:0]    height_ext;
    logic [AW+abst_pkg::SLOT_W-1:0]      slot_ext;
    logic [KEY_BITS+abst_pkg::KEY_W-1:0] min_ext;
    logic [KEY_BITS+abst_pkg::KEY_W-1:0] max_ext;

    // Key masked to the stored width
    assign key_ext = {{KEY_BITS{1'b0}}, in_key};
    assign key_eff = key_ext[KEY_BITS-1:0];

    // Shared compare unit: request key against the node just read
    assign node_empty = (mem_rdata == '0);
    assign node_hit   = (key_reg == mem_rdata);
    assign go_right   = (key_reg > mem_rdata);
    assign at_last    = (depth_reg == DW'(LEVELS - 1));
    assign child_w    = {idx_reg, 1'b0} + (go_right ? (AW+1)'(2) : (AW+1)'(1));
    assign child      = child_w[AW-1:0];

    // Sequencer
    always_comb begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        idx_next    = idx_reg;
        depth_next  = depth_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        found_next  = found_reg;
        status_next = status_reg;
        slot_next   = slot_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        height_next = height_reg;
        empty_next  = empty_reg;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg;
        mem_wdata   = key_reg;
        mem_raddr   = '0;

        case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(STORE_SIZE - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                // root is read at the accepting edge
                if (in_valid) begin
                    op_next    = in_op;
                    key_next   = key_eff;
                    idx_next   = '0;
                    depth_next = '0;
                    found_next = 1'b0;
                    slot_next  = '0;
                    if (key_eff == '0) begin
                        status_next = abst_pkg::ST_ZERO;
                        state_next  = S_EMIT;
                    end else begin
                        status_next = abst_pkg::ST_OK;
                        state_next  = S_WALK;
                    end
                end
            end
            S_WALK: begin
                mem_raddr = at_last ? '0 : child;
                if (op_reg == abst_pkg::OP_SEARCH) begin
                    if (node_empty) begin
                        state_next = S_EMIT;
                    end else if (node_hit) begin
                        found_next = 1'b1;
                        slot_next  = idx_reg;
                        state_next = S_EMIT;
                    end else if (at_last) begin
                        state_next = S_EMIT;
                    end else begin
                        idx_next   = child;
                        depth_next = depth_reg + DW'(1);
                    end
                end else begin
                    if (node_empty) begin
                        // free slot: store key and update the summary
                        mem_we     = 1'b1;
                        slot_next  = idx_reg;
                        empty_next = 1'b0;
                        if (empty_reg) begin
                            min_next    = key_reg;
                            max_next    = key_reg;
                            height_next = depth_reg;
                        end else begin
                            if (key_reg < min_reg) begin
                                min_next = key_reg;
                            end
                            if (key_reg > max_reg) begin
                                max_next = key_reg;
                            end
                            if (depth_reg > height_reg) begin
                                height_next = depth_reg;
                            end
                        end
                        state_next = S_EMIT;
                    end else if (at_last) begin
                        status_next = abst_pkg::ST_FULL;
                        state_next  = S_EMIT;
                    end else begin
                        idx_next   = child;
                        depth_next = depth_reg + DW'(1);
                    end
                end
            end
            S_EMIT: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            min_reg    <= '0;
            max_reg    <= '0;
            height_reg <= '0;
            empty_reg  <= 1'b1;
        end else begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            min_reg    <= min_next;
            max_reg    <= max_next;
            height_reg <= height_next;
            empty_reg  <= empty_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        depth_reg  <= depth_next;
        op_reg     <= op_next;
        key_reg    <= key_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
    end

    // Result fields cut to port widths
    assign height_ext = {{abst_pkg::HEIGHT_W{1'b0}}, height_reg};
    assign slot_ext   = {{abst_pkg::SLOT_W{1'b0}}, slot_reg};
    assign min_ext    = {{abst_pkg::KEY_W{1'b0}}, min_reg};
    assign max_ext    = {{abst_pkg::KEY_W{1'b0}}, max_reg};

    always_comb begin
        res.found       = found_reg;
        res.status      = status_reg;
        res.slot        = slot_ext[abst_pkg::SLOT_W-1:0];
        res.min_key     = min_ext[abst_pkg::KEY_W-1:0];
        res.max_key     = max_ext[abst_pkg::KEY_W-1:0];
        res.tree_height = empty_reg ? {abst_pkg::HEIGHT_W{1'b1}}
                                    : height_ext[abst_pkg::HEIGHT_W-1:0];
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_EMIT);

    // Checks
    a_walk_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK) |-> (depth_reg <= DW'(LEVELS - 1)))
        else $error("walk went below the last level");

    a_write_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && state_reg == S_WALK) |=> (state_reg == S_EMIT))
        else $error("insert write did not end the walk");

    a_min_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (!empty_reg) |-> (min_reg <= max_reg))
        else $error("smallest key above largest key");

    a_accept_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> (state_reg == S_WALK || state_reg == S_EMIT))
        else $error("accepted request not started");

    a_full_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.status == abst_pkg::ST_FULL) |-> (op_reg == abst_pkg::OP_INSERT))
        else $error("full status on a search");

endmodule

[design/array_bst_insert_search_top.sv]
`timescale 1ns / 1ps

// Binary search tree in an implicit array of 2^LEVELS-1 slots (children of
// slot i at 2i+1 and 2i+2, zero marks an empty slot). Each request inserts
// or searches one key; every result also carries the current smallest key,
// largest key and tree height. After reset every slot of the store is cleared
// in turn while s_tready stays low. A request is then accepted and walks the
// tree one level at a time (at most LEVELS levels, set by the single
// registered read port of the store); its result is then handed to the
// output register. A zero key skips the walk. The hand-over waits while the
// output register is still full and m_tready is low. One request is in flight
// at a time; a new one is accepted while the previous result still waits in
// the output register.
module array_bst_insert_search_top #(
    parameter int LEVELS   = abst_pkg::LEVELS_DEF,
    parameter int KEY_BITS = abst_pkg::KEY_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [0] operation, [16:1] key
    input  logic [abst_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] found, [2:1] status, [8:3] slot, [24:9] min_key, [40:25] max_key,
    // [44:41] tree_height
    output logic [abst_pkg::OUT_DATA_W-1:0] m_tdata
);

    localparam int STORE_SIZE = (1 << LEVELS) - 1;

    logic                  res_valid;
    logic                  res_ready;
    abst_pkg::res_t        res;
    logic                  mem_we;
    logic [LEVELS-1:0]     mem_waddr;
    logic [KEY_BITS-1:0]   mem_wdata;
    logic [LEVELS-1:0]     mem_raddr;
    logic [KEY_BITS-1:0]   mem_rdata;

    logic                  out_valid_reg, out_valid_next;
    abst_pkg::res_t        out_data_reg, out_data_next;

    abst_ctrl #(
        .LEVELS   (LEVELS),
        .KEY_BITS (KEY_BITS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tdata[0]),
        .in_key    (s_tdata[abst_pkg::KEY_W:1]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    abst_mem #(
        .AW    (LEVELS),
        .DW    (KEY_BITS),
        .DEPTH (STORE_SIZE)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Output register
    assign res_ready = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid && res_ready) begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_data_reg};

endmodule

[bench/array_bst_insert_search_top_test.sv]
`timescale 1ns / 1ps

module array_bst_insert_search_top_test;

    localparam int STORE_SLOTS = (1 << abst_pkg::LEVELS_DEF) - 1;
    localparam int IDLE_PCT    = 28;
    localparam int DRAIN_WAIT  = abst_pkg::LEVELS_DEF + 6;
    localparam int STALL_LIMIT = 1000;
    localparam int RANDOM_REQS = 680;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [abst_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [abst_pkg::OUT_DATA_W-1:0] m_tdata;

    // Shadow of the tree and its summary registers
    logic [abst_pkg::KEY_W-1:0] tree_keys [STORE_SLOTS];
    logic [abst_pkg::KEY_W-1:0] key_min;
    logic [abst_pkg::KEY_W-1:0] key_max;
    int                         tree_ht;
    logic [abst_pkg::KEY_W-1:0] stored_keys [$];

    abst_pkg::res_t pending_results [$];

    bit steady      = 1'b0;
    int error_count = 0;
    int idle_cycles = 0;
    int n_insert    = 0;
    int n_search    = 0;
    int n_hit       = 0;
    int n_full      = 0;
    int n_zero      = 0;
    int n_checked   = 0;

    array_bst_insert_search_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Walk the shadow tree for one request and return the expected result
    function automatic abst_pkg::res_t bst_apply(input logic op,
                                                 input logic [abst_pkg::KEY_W-1:0] key);
        abst_pkg::res_t r;
        int idx;
        int depth;
        r     = '0;
        idx   = 0;
        depth = 0;
        if (key == '0) begin
            r.status = abst_pkg::ST_ZERO;
            n_zero++;
        end else if (op == abst_pkg::OP_SEARCH) begin
            n_search++;
            while (idx < STORE_SLOTS && tree_keys[idx] != '0) begin
                if (key == tree_keys[idx]) begin
                    r.found = 1'b1;
                    r.slot  = abst_pkg::SLOT_W'(idx);
                    n_hit++;
                    break;
                end
                idx = (key > tree_keys[idx]) ? 2 * idx + 2 : 2 * idx + 1;
            end
        end else begin
            n_insert++;
            // equal keys go left
            while (idx < STORE_SLOTS && tree_keys[idx] != '0) begin
                idx = (key > tree_keys[idx]) ? 2 * idx + 2 : 2 * idx + 1;
                depth++;
            end
            if (idx >= STORE_SLOTS) begin
                r.status = abst_pkg::ST_FULL;
                n_full++;
            end else begin
                tree_keys[idx] = key;
                stored_keys.push_back(key);
                if (tree_ht < 0) begin
                    key_min = key;
                    key_max = key;
                end else begin
                    if (key < key_min) key_min = key;
                    if (key > key_max) key_max = key;
                end
                if (depth > tree_ht) tree_ht = depth;
                r.slot = abst_pkg::SLOT_W'(idx);
            end
        end
        r.min_key     = key_min;
        r.max_key     = key_max;
        r.tree_height = abst_pkg::HEIGHT_W'(tree_ht);
        return r;
    endfunction

    // Present one request, wait for the handshake, then log its expectation
    task automatic send_request(input logic op, input logic [abst_pkg::KEY_W-1:0] key);
        if (!steady) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(abst_pkg::IN_DATA_W - abst_pkg::KEY_W - 1){1'b0}}, key, op};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(bst_apply(op, key));
    endtask

    task automatic test_empty_tree();
        send_request(abst_pkg::OP_SEARCH, 16'd5);
        send_request(abst_pkg::OP_SEARCH, 16'hFFFF);
    endtask

    task automatic test_zero_key();
        send_request(abst_pkg::OP_INSERT, 16'd0);
        send_request(abst_pkg::OP_SEARCH, 16'd0);
    endtask

    // Root, duplicate to the left, extremes of the key range, search hits and misses
    task automatic test_insert_order();
        send_request(abst_pkg::OP_INSERT, 16'h8000);
        send_request(abst_pkg::OP_INSERT, 16'h8000);
        send_request(abst_pkg::OP_SEARCH, 16'h8000);
        send_request(abst_pkg::OP_INSERT, 16'hFFFF);
        send_request(abst_pkg::OP_INSERT, 16'h0001);
        send_request(abst_pkg::OP_SEARCH, 16'hFFFF);
        send_request(abst_pkg::OP_SEARCH, 16'h0001);
        send_request(abst_pkg::OP_SEARCH, 16'h7FFF);
        send_request(abst_pkg::OP_INSERT, 16'h5555);
        send_request(abst_pkg::OP_INSERT, 16'hAAAA);
    endtask

    // Repeated smallest key runs down the left spine until it falls off the store
    task automatic test_path_full();
        repeat (5) send_request(abst_pkg::OP_INSERT, 16'h0001);
        send_request(abst_pkg::OP_SEARCH, 16'h0001);
        send_request(abst_pkg::OP_INSERT, 16'h0000);
    endtask

    task automatic test_random_mix();
        logic                       op;
        logic [abst_pkg::KEY_W-1:0] key;
        int                         pick;
        for (int i = 0; i < RANDOM_REQS; i++) begin
            steady = (i >= 250 && i < 400);
            op     = ($urandom_range(0, 99) < 50) ? abst_pkg::OP_SEARCH : abst_pkg::OP_INSERT;
            pick   = $urandom_range(0, 99);
            if (pick < 5)
                key = '0;
            else if (pick < ((op == abst_pkg::OP_SEARCH) ? 60 : 12) && stored_keys.size() > 0)
                key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            else if (pick < 70)
                key = 16'($urandom_range(1, 16'hFFFF));
            else
                key = 16'($urandom_range(1, 64));
            send_request(op, key);
        end
        steady = 1'b0;
    endtask

    // Result side: random back-pressure, quiet during the steady window
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Compare each result with the oldest expectation
    always @(posedge aclk) begin
        abst_pkg::res_t want;
        abst_pkg::res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = abst_pkg::res_t'(m_tdata[$bits(abst_pkg::res_t)-1:0]);
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (got.found !== want.found) begin
                    $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
                    error_count++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                    error_count++;
                end
                if (got.slot !== want.slot) begin
                    $display("%0t: slot expected %0d actual %0d", $time, want.slot, got.slot);
                    error_count++;
                end
                if (got.min_key !== want.min_key) begin
                    $display("%0t: min_key expected %h actual %h",
                             $time, want.min_key, got.min_key);
                    error_count++;
                end
                if (got.max_key !== want.max_key) begin
                    $display("%0t: max_key expected %h actual %h",
                             $time, want.max_key, got.max_key);
                    error_count++;
                end
                if (got.tree_height !== want.tree_height) begin
                    $display("%0t: tree_height expected %h actual %h",
                             $time, want.tree_height, got.tree_height);
                    error_count++;
                end
                if (m_tdata[abst_pkg::OUT_DATA_W-1:$bits(abst_pkg::res_t)] !== '0) begin
                    $display("%0t: padding expected 0 actual %h", $time,
                             m_tdata[abst_pkg::OUT_DATA_W-1:$bits(abst_pkg::res_t)]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: cycles without any request or result moving
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("array_bst_insert_search_top_test: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < STORE_SLOTS; i++) tree_keys[i] = '0;
        key_min = '0;
        key_max = '0;
        tree_ht = -1;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_tree();
        test_zero_key();
        test_insert_order();
        test_path_full();
        test_random_mix();
        s_tvalid <= 1'b0;

        // drain, then watch for stray results
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Covered %0d inserts (%0d path full), %0d searches (%0d hits), %0d zero keys;",
                 n_insert, n_full, n_search, n_hit, n_zero);
        $display("%0d results checked, final height %0d, %0d keys stored.",
                 n_checked, tree_ht, stored_keys.size());
        if (error_count == 0) begin
            $display("array_bst_insert_search_top_test: clean");
        end else begin
            $display("array_bst_insert_search_top_test: errors");
        end
        $finish;
    end

endmodule

[files.f]
design/abst_pkg.sv
design/abst_mem.sv
design/abst_ctrl.sv
design/array_bst_insert_search_top.sv
bench/array_bst_insert_search_top_test.sv
